FILE: hdl/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk, off during rst
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during rst
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/sal_pkg.sv
// Package: sizes, codes and types of the sorted access-list table
`default_nettype none
package sal_pkg;

  localparam int MAX_ENTRIES = 32;
  localparam int MODE_BITS   = 7;
  localparam int KIND_W      = 2;
  localparam int ID_W        = 32;
  localparam int REQ_W       = 3;
  localparam int STAT_W      = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  // request codes
  localparam logic [REQ_W-1:0] REQ_GRANT    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_REVOKE   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_SET      = 3'd2;
  localparam logic [REQ_W-1:0] REQ_REMOVE   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CONTAINS = 3'd4;
  localparam logic [REQ_W-1:0] REQ_DEFAULT  = 3'd5;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_WORLD = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OWNER_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WORLD_MODE = 1'd1;

  // identity kinds
  localparam logic [KIND_W-1:0] KIND_WORLD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_USER  = 2'd1;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   id;
  } key_t;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [ID_W-1:0]      id;
    logic [MODE_BITS-1:0] mode;
  } entry_t;

  // per-cell update command
  typedef enum logic [2:0] {
    OP_HOLD  = 3'd0,
    OP_NEW   = 3'd1,
    OP_LEFT  = 3'd2,
    OP_RIGHT = 3'd3,
    OP_MODE  = 3'd4
  } cell_op_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_UPD  = 2'b10
  } state_t;

endpackage
`default_nettype wire

FILE: hdl/sal_ifs.sv
// Interfaces: request, response and configuration channels
`default_nettype none
interface sal_req_if;
  logic                            valid;
  logic                            ready;
  logic [sal_pkg::REQ_W-1:0]       req_type;
  logic [sal_pkg::KIND_W-1:0]      id_kind;
  logic [sal_pkg::ID_W-1:0]        entry_id;
  logic [sal_pkg::MODE_BITS-1:0]   mode_bits;
  modport source (output valid, req_type, id_kind, entry_id, mode_bits, input ready);
  modport sink   (input valid, req_type, id_kind, entry_id, mode_bits, output ready);
endinterface

interface sal_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [sal_pkg::STAT_W-1:0]      status;
  logic                            matched;
  logic [sal_pkg::MODE_BITS-1:0]   result_mode;
  logic [sal_pkg::CNT_W-1:0]       entry_count;
  modport source (output valid, status, matched, result_mode, entry_count, input ready);
  modport sink   (input valid, status, matched, result_mode, entry_count, output ready);
endinterface

interface sal_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [sal_pkg::CFG_IDX_W-1:0]   index;
  logic [sal_pkg::MODE_BITS-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: hdl/sal_cell.sv
// One table cell: holds an entry, compares it with the key, shifts to or from neighbours
`default_nettype none
module sal_cell (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire sal_pkg::cell_op_t cmd,
  input  wire sal_pkg::key_t     key,
  input  wire sal_pkg::entry_t   left,
  input  wire sal_pkg::entry_t   right,
  input  wire sal_pkg::entry_t   new_ent,
  input  wire logic [sal_pkg::MODE_BITS-1:0] wr_mode,
  output sal_pkg::entry_t        cur,
  output logic                   gt,
  output logic                   eq
);

  sal_pkg::entry_t ent;

  assign cur = ent;
  assign eq  = (key.kind == ent.kind) && (key.id == ent.id);
  assign gt  = (key.kind > ent.kind) || ((key.kind == ent.kind) && (key.id > ent.id));

  always_ff @(posedge clk) begin
    if (rst) begin
      ent <= '0;
    end else begin
      unique case (cmd)
        sal_pkg::OP_HOLD:  ent <= ent;
        sal_pkg::OP_NEW:   ent <= new_ent;
        sal_pkg::OP_LEFT:  ent <= left;
        sal_pkg::OP_RIGHT: ent <= right;
        sal_pkg::OP_MODE:  ent.mode <= wr_mode;
        default:           ent <= ent;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hdl/sorted_access_list_table_unit.sv
// Top level: sorted access-list table built as a row of shifting cells
//
//  channel | dir | handshake     | payload
//  cfg     | in  | valid / ready | index, data (owner/world default masks)
//  req     | in  | valid / ready | req_type, id_kind, entry_id, mode_bits
//  rsp     | out | valid / ready | status, matched, result_mode, entry_count
//
// One request at a time: at the req transfer every cell compares the key at
// once and the match vectors are registered; in the update state (S_UPD) the cells rewrite,
// shift left or shift right together and the response register is loaded.
// Reset leaves the world entry alone in the table.
// A held response stalls the update cycle; cfg is always ready.
`default_nettype none
module sorted_access_list_table_unit (
  input  wire logic clk,
  input  wire logic rst,
  sal_cfg_if.sink   cfg,
  sal_req_if.sink   req,
  sal_rsp_if.source rsp
);

  localparam int N  = sal_pkg::MAX_ENTRIES;
  localparam int MB = sal_pkg::MODE_BITS;

  sal_pkg::state_t                 state;
  logic [MB-1:0]                   owner_mode;
  logic [MB-1:0]                   world_mode;
  logic [sal_pkg::CNT_W-1:0]       count;
  logic [sal_pkg::CNT_W-1:0]       count_next;

  logic [sal_pkg::REQ_W-1:0]       req_q;
  sal_pkg::key_t                   key_q;
  logic [MB-1:0]                   mb_q;
  logic [N-1:0]                    gt_q;
  logic [N-1:0]                    eq_q;
  logic [MB-1:0]                   hit_mode_q;

  logic                            out_valid;
  logic [sal_pkg::STAT_W-1:0]      out_status;
  logic                            out_matched;
  logic [MB-1:0]                   out_mode;
  logic [sal_pkg::CNT_W-1:0]       out_count;

  sal_pkg::key_t                   key_in;
  sal_pkg::entry_t                 cur     [N];
  sal_pkg::entry_t                 left_in [N];
  sal_pkg::entry_t                 right_in[N];
  sal_pkg::cell_op_t               cmd_c   [N];
  sal_pkg::cell_op_t               cmd     [N];
  logic [N-1:0]                    gt_raw;
  logic [N-1:0]                    eq_raw;
  logic [N-1:0]                    vld;
  logic [N-1:0]                    at_dst;
  logic [N-1:0]                    after_dst;
  logic [MB-1:0]                   hit_mode_c;
  sal_pkg::entry_t                 new_ent;
  logic [MB-1:0]                   wr_mode;
  logic [MB-1:0]                   m_upd;
  logic [MB-1:0]                   m_ins;
  logic                            hit;
  logic                            full;
  logic [sal_pkg::STAT_W-1:0]      st_c;
  logic                            mt_c;
  logic [MB-1:0]                   rm_c;

  logic req_xfer;
  logic proceed;

  assign req.ready = (state == sal_pkg::S_IDLE);
  assign req_xfer  = req.valid && req.ready;
  assign proceed   = (state == sal_pkg::S_UPD) && (!out_valid || rsp.ready);
  assign cfg.ready = 1'b1;

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.matched     = out_matched;
  assign rsp.result_mode = out_mode;
  assign rsp.entry_count = out_count;

  assign key_in.kind = req.id_kind;
  assign key_in.id   = req.entry_id;

  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_in[i] = '0;
    end else begin : g_mid
      assign left_in[i] = cur[i-1];
    end
    if (i == N - 1) begin : g_last
      assign right_in[i] = '0;
    end else begin : g_inner
      assign right_in[i] = cur[i+1];
    end
    assign vld[i] = count > sal_pkg::CNT_W'(i);
    assign cmd[i] = proceed ? cmd_c[i] : sal_pkg::OP_HOLD;

    sal_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .cmd     (cmd[i]),
      .key     (key_in),
      .left    (left_in[i]),
      .right   (right_in[i]),
      .new_ent (new_ent),
      .wr_mode (wr_mode),
      .cur     (cur[i]),
      .gt      (gt_raw[i]),
      .eq      (eq_raw[i])
    );
  end

  always_comb begin
    hit_mode_c = '0;
    for (int i = 0; i < N; i++) begin
      if (eq_raw[i] && vld[i]) hit_mode_c = hit_mode_c | cur[i].mode;
    end
  end

  // gt_q is a prefix: dst is the first cell without it
  always_comb begin
    at_dst[0]    = !gt_q[0];
    after_dst[0] = 1'b0;
    for (int i = 1; i < N; i++) begin
      at_dst[i]    = gt_q[i-1] && !gt_q[i];
      after_dst[i] = !gt_q[i-1];
    end
  end

  always_comb begin
    hit  = |eq_q;
    full = (count >= sal_pkg::CNT_W'(N));
    unique case (req_q)
      sal_pkg::REQ_GRANT:  m_upd = hit_mode_q | mb_q;
      sal_pkg::REQ_REVOKE: m_upd = hit_mode_q & ~mb_q;
      default:             m_upd = mb_q;
    endcase
    m_ins = (req_q == sal_pkg::REQ_REVOKE) ? '0 : mb_q;

    for (int i = 0; i < N; i++) cmd_c[i] = sal_pkg::OP_HOLD;
    new_ent.kind = key_q.kind;
    new_ent.id   = key_q.id;
    new_ent.mode = m_ins;
    wr_mode      = m_upd;
    st_c         = sal_pkg::STAT_OK;
    mt_c         = 1'b0;
    rm_c         = '0;
    count_next   = count;

    unique case (req_q) inside
      sal_pkg::REQ_GRANT, sal_pkg::REQ_REVOKE, sal_pkg::REQ_SET: begin
        if (hit) begin
          mt_c = 1'b1;
          if (m_upd == '0 && gt_q[0]) begin
            for (int i = 0; i < N; i++) begin
              if (at_dst[i] || after_dst[i]) cmd_c[i] = sal_pkg::OP_RIGHT;
            end
            count_next = count - sal_pkg::CNT_W'(1);
          end else begin
            for (int i = 0; i < N; i++) begin
              if (eq_q[i]) cmd_c[i] = sal_pkg::OP_MODE;
            end
            rm_c = m_upd;
          end
        end else if (!gt_q[0]) begin
          st_c = sal_pkg::STAT_WORLD;
        end else if (m_ins != '0) begin
          if (full) begin
            st_c = sal_pkg::STAT_FULL;
          end else begin
            for (int i = 0; i < N; i++) begin
              if (at_dst[i]) cmd_c[i] = sal_pkg::OP_NEW;
              else if (after_dst[i]) cmd_c[i] = sal_pkg::OP_LEFT;
            end
            count_next = count + sal_pkg::CNT_W'(1);
            rm_c       = m_ins;
          end
        end
      end
      sal_pkg::REQ_REMOVE: begin
        if (hit) begin
          mt_c = 1'b1;
          if (eq_q[0]) begin
            st_c = sal_pkg::STAT_WORLD;
            rm_c = hit_mode_q;
          end else begin
            for (int i = 0; i < N; i++) begin
              if (at_dst[i] || after_dst[i]) cmd_c[i] = sal_pkg::OP_RIGHT;
            end
            count_next = count - sal_pkg::CNT_W'(1);
          end
        end
      end
      sal_pkg::REQ_CONTAINS: begin
        rm_c = hit ? hit_mode_q : '0;
        mt_c = hit && (hit_mode_q == mb_q);
      end
      sal_pkg::REQ_DEFAULT: begin
        cmd_c[0] = sal_pkg::OP_MODE;
        wr_mode  = world_mode;
        if (key_q.id != '0) begin
          cmd_c[1]     = sal_pkg::OP_NEW;
          new_ent.kind = sal_pkg::KIND_USER;
          new_ent.mode = owner_mode;
          count_next   = sal_pkg::CNT_W'(2);
          mt_c         = 1'b1;
          rm_c         = owner_mode;
        end else begin
          count_next = sal_pkg::CNT_W'(1);
          rm_c       = world_mode;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owner_mode <= '1;
      world_mode <= '0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        sal_pkg::CFG_OWNER_MODE: owner_mode <= cfg.data;
        sal_pkg::CFG_WORLD_MODE: world_mode <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sal_pkg::S_IDLE;
      count <= sal_pkg::CNT_W'(1);
    end else begin
      unique case (state)
        sal_pkg::S_IDLE: if (req_xfer) state <= sal_pkg::S_UPD;
        sal_pkg::S_UPD: begin
          if (proceed) begin
            state <= sal_pkg::S_IDLE;
            count <= count_next;
          end
        end
        default: state <= sal_pkg::S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req_xfer) begin
      req_q      <= req.req_type;
      key_q      <= key_in;
      mb_q       <= req.mode_bits;
      gt_q       <= gt_raw & vld;
      eq_q       <= eq_raw & vld;
      hit_mode_q <= hit_mode_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proceed) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proceed) begin
      out_status  <= st_c;
      out_matched <= mt_c;
      out_mode    <= rm_c;
      out_count   <= count_next;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/sal_checker.sv
// Port checker for the sorted access-list table, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module sal_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               req_valid,
  input wire logic                               req_ready,
  input wire logic                               rsp_valid,
  input wire logic                               rsp_ready,
  input wire logic [sal_pkg::STAT_W-1:0]         status,
  input wire logic                               matched,
  input wire logic [sal_pkg::MODE_BITS-1:0]      result_mode,
  input wire logic [sal_pkg::CNT_W-1:0]          entry_count
);

  `ASSERT_IMPL(a_count_range, rsp_valid, (entry_count >= sal_pkg::CNT_W'(1)) && (entry_count <= sal_pkg::CNT_W'(sal_pkg::MAX_ENTRIES)), "entry count out of range")
  `ASSERT_IMPL(a_full_clean, rsp_valid && (status == sal_pkg::STAT_FULL), !matched && (result_mode == '0), "full table response carries a match")
  `ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready, "request taken during update cycle")
  `ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(matched) && $stable(result_mode) && $stable(entry_count), "stalled response changed")

endmodule

bind sorted_access_list_table_unit sal_checker u_sal_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .status      (rsp.status),
  .matched     (rsp.matched),
  .result_mode (rsp.result_mode),
  .entry_count (rsp.entry_count)
);
`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for the sorted access-list table: directed rows, then random traffic
`default_nettype none
module testbench;
  import sal_pkg::*;

  localparam logic [REQ_W-1:0]  REQ_SPARE6 = 3'd6;
  localparam logic [REQ_W-1:0]  REQ_SPARE7 = 3'd7;
  localparam logic [KIND_W-1:0] KIND_GROUP = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  localparam int DIRECTED_ROWS  = 23;
  localparam int PHASE_ITEMS    = 182;
  localparam int SEGMENT_ITEMS  = 60;
  localparam int HOLD_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int MAX_REPORTS    = 50;

  localparam logic [MODE_BITS-1:0] PHASE_OWNER [3] = '{7'h00, 7'h55, 7'h00};
  localparam logic [MODE_BITS-1:0] PHASE_WORLD [3] = '{7'h7F, 7'h2A, 7'h00};

  typedef struct packed {
    logic [STAT_W-1:0]    status;
    logic                 matched;
    logic [MODE_BITS-1:0] result_mode;
    logic [CNT_W-1:0]     entry_count;
  } outcome_t;

  typedef struct packed {
    logic [REQ_W-1:0]     rq;
    logic [KIND_W-1:0]    kind;
    logic [ID_W-1:0]      id;
    logic [MODE_BITS-1:0] mode;
    logic                 typed;
    outcome_t             want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sal_cfg_if cfg_ch ();
  sal_req_if req_ch ();
  sal_rsp_if rsp_ch ();

  sorted_access_list_table_unit i_dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // shadow of the table and its default masks
  entry_t               acl [MAX_ENTRIES];
  int                   acl_used;
  logic [MODE_BITS-1:0] owner_cfg;
  logic [MODE_BITS-1:0] world_cfg;

  outcome_t outcome_q [$];
  logic     cur_typed = 1'b0;
  outcome_t cur_want  = '0;
  int       failures = 0;
  int       checked = 0;
  int       idle_cycles = 0;
  int       send_calm = 0;
  int       recv_calm = 0;
  bit       hold_request = 1'b0;

  row_t plan [DIRECTED_ROWS] = '{
    '{REQ_CONTAINS, KIND_WORLD, 32'd0,          7'h00, 1'b1, '{STAT_OK,    1'b1, 7'h00, 6'd1}},
    '{REQ_GRANT,    KIND_USER,  32'hFFFF_FFFF,  7'h7F, 1'b1, '{STAT_OK,    1'b0, 7'h7F, 6'd2}},
    '{REQ_GRANT,    KIND_WORLD, 32'd0,          7'h7F, 1'b1, '{STAT_OK,    1'b1, 7'h7F, 6'd2}},
    '{REQ_REMOVE,   KIND_WORLD, 32'd0,          7'h00, 1'b1, '{STAT_WORLD, 1'b1, 7'h7F, 6'd2}},
    '{REQ_REVOKE,   KIND_WORLD, 32'd0,          7'h7F, 1'b1, '{STAT_OK,    1'b1, 7'h00, 6'd2}},
    '{REQ_REVOKE,   KIND_GROUP, 32'd5,          7'h01, 1'b1, '{STAT_OK,    1'b0, 7'h00, 6'd2}},
    '{REQ_SET,      KIND_GROUP, 32'd5,          7'h00, 1'b1, '{STAT_OK,    1'b0, 7'h00, 6'd2}},
    '{REQ_SET,      KIND_GROUP, 32'd5,          7'h40, 1'b0, '0},
    '{REQ_GRANT,    KIND_SPARE, 32'd0,          7'h01, 1'b0, '0},
    '{REQ_GRANT,    KIND_WORLD, 32'd1,          7'h02, 1'b0, '0},
    '{REQ_CONTAINS, KIND_GROUP, 32'd5,          7'h40, 1'b0, '0},
    '{REQ_CONTAINS, KIND_GROUP, 32'd5,          7'h41, 1'b0, '0},
    '{REQ_REVOKE,   KIND_GROUP, 32'd5,          7'h40, 1'b0, '0},
    '{REQ_REMOVE,   KIND_GROUP, 32'd5,          7'h00, 1'b0, '0},
    '{REQ_REMOVE,   KIND_SPARE, 32'd0,          7'h00, 1'b0, '0},
    '{REQ_SET,      KIND_USER,  32'hFFFF_FFFF,  7'h2A, 1'b0, '0},
    '{REQ_GRANT,    KIND_USER,  32'd0,          7'h55, 1'b0, '0},
    '{REQ_SPARE6,   KIND_GROUP, 32'd7,          7'h7F, 1'b1, '{STAT_OK,    1'b0, 7'h00, 6'd4}},
    '{REQ_SPARE7,   KIND_SPARE, 32'hFFFF_FFFF,  7'h7F, 1'b1, '{STAT_OK,    1'b0, 7'h00, 6'd4}},
    '{REQ_DEFAULT,  KIND_WORLD, 32'd0,          7'h00, 1'b1, '{STAT_OK,    1'b0, 7'h00, 6'd1}},
    '{REQ_DEFAULT,  KIND_USER,  32'hFFFF_FFFF,  7'h00, 1'b1, '{STAT_OK,    1'b1, 7'h7F, 6'd2}},
    '{REQ_GRANT,    KIND_USER,  32'hFFFF_FFFF,  7'h00, 1'b0, '0},
    '{REQ_REVOKE,   KIND_USER,  32'hFFFF_FFFF,  7'h7F, 1'b0, '0}
  };

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void load_defaults(logic [ID_W-1:0] owner);
    acl[0]   = '{KIND_WORLD, '0, world_cfg};
    acl_used = 1;
    if (owner != '0) begin
      acl[1]   = '{KIND_USER, owner, owner_cfg};
      acl_used = 2;
    end
  endfunction

  function automatic void drop_entry(int pos);
    for (int i = pos; i + 1 < acl_used; i++) acl[i] = acl[i + 1];
    acl_used--;
  endfunction

  function automatic outcome_t apply_acl_request(logic [REQ_W-1:0] rq, logic [KIND_W-1:0] k,
                                                 logic [ID_W-1:0] id, logic [MODE_BITS-1:0] mb);
    outcome_t             o;
    int                   dst;
    logic [MODE_BITS-1:0] m;
    o   = '0;
    dst = 0;
    if (rq == REQ_GRANT || rq == REQ_REVOKE || rq == REQ_SET) begin
      while (dst < acl_used && {k, id} > {acl[dst].kind, acl[dst].id}) dst++;
      if (dst < acl_used && acl[dst].kind == k && acl[dst].id == id) begin
        o.matched = 1'b1;
        m = acl[dst].mode;
        case (rq)
          REQ_GRANT:  m = m | mb;
          REQ_REVOKE: m = m & ~mb;
          default:    m = mb;
        endcase
        // world entry survives an empty mask
        if (m == '0 && dst > 0) begin
          drop_entry(dst);
        end else begin
          acl[dst].mode = m;
          o.result_mode = m;
        end
      end else if (dst == 0) begin
        o.status = STAT_WORLD;
      end else begin
        m = (rq == REQ_REVOKE) ? '0 : mb;
        if (m != '0) begin
          if (acl_used >= MAX_ENTRIES) begin
            o.status = STAT_FULL;
          end else begin
            for (int i = acl_used; i > dst; i--) acl[i] = acl[i - 1];
            acl[dst] = '{k, id, m};
            acl_used++;
            o.result_mode = m;
          end
        end
      end
    end else if (rq == REQ_REMOVE) begin
      while (dst < acl_used && !(acl[dst].kind == k && acl[dst].id == id)) dst++;
      if (dst < acl_used) begin
        o.matched = 1'b1;
        if (dst == 0) begin
          o.status      = STAT_WORLD;
          o.result_mode = acl[0].mode;
        end else begin
          drop_entry(dst);
        end
      end
    end else if (rq == REQ_CONTAINS) begin
      for (int i = 0; i < acl_used; i++) begin
        if (acl[i].kind == k && acl[i].id == id) begin
          o.result_mode = acl[i].mode;
          if (acl[i].mode == mb) o.matched = 1'b1;
        end
      end
    end else if (rq == REQ_DEFAULT) begin
      load_defaults(id);
      if (id != '0) begin
        o.matched     = 1'b1;
        o.result_mode = acl[1].mode;
      end else begin
        o.result_mode = acl[0].mode;
      end
    end
    o.entry_count = CNT_W'(acl_used);
    return o;
  endfunction

  task automatic report_mismatch(string what, int got_v, int want_v);
    failures++;
    if (failures <= MAX_REPORTS)
      $display("ERROR %s: got %0d, expected %0d (response %0d)", what, got_v, want_v, checked);
  endtask

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_request(input row_t r);
    int gap;
    if (send_calm > 0) begin
      send_calm--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 5);
      if ($urandom_range(0, 29) == 0) send_calm = $urandom_range(10, 30);
    end
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.req_type  = r.rq;
    req_ch.id_kind   = r.kind;
    req_ch.entry_id  = r.id;
    req_ch.mode_bits = r.mode;
    cur_typed        = r.typed;
    cur_want         = r.want;
    req_ch.valid     = 1'b1;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic write_defaults(input logic [MODE_BITS-1:0] owner_v,
                                input logic [MODE_BITS-1:0] world_v);
    cfg_ch.index = CFG_OWNER_MODE;
    cfg_ch.data  = owner_v;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    @(negedge clk);
    cfg_ch.index = CFG_WORLD_MODE;
    cfg_ch.data  = world_v;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic drain();
    req_ch.valid = 1'b0;
    while (outcome_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin : stimulus
    row_t r;
    int   useful;
    int   seg_left;
    int   pick;
    bit   growth;
    req_ch.valid     = 1'b0;
    req_ch.req_type  = REQ_GRANT;
    req_ch.id_kind   = KIND_WORLD;
    req_ch.entry_id  = '0;
    req_ch.mode_bits = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = CFG_OWNER_MODE;
    cfg_ch.data      = '0;
    owner_cfg        = 7'h7F;
    world_cfg        = '0;
    load_defaults('0);
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    write_defaults(7'h7F, 7'h00);
    foreach (plan[i]) send_request(plan[i]);

    for (int p = 0; p < 4; p++) begin
      drain();
      if (p == 3) write_defaults(MODE_BITS'($urandom_range(0, 127)),
                                 MODE_BITS'($urandom_range(0, 127)));
      else write_defaults(PHASE_OWNER[p], PHASE_WORLD[p]);
      if (p == 0) hold_request = 1'b1;
      useful   = 0;
      seg_left = 0;
      growth   = 1'b0;
      while (useful < PHASE_ITEMS) begin
        // growth segments fill the table up to its limit
        if (seg_left == 0) begin
          growth   = (p == 0 && useful == 0) || ($urandom_range(0, 2) == 0);
          seg_left = SEGMENT_ITEMS;
        end
        seg_left--;
        r    = '0;
        pick = $urandom_range(0, 99);
        if (growth)
          r.rq = (pick < 88) ? REQ_GRANT : (pick < 92) ? REQ_SET :
                 (pick < 96) ? REQ_CONTAINS : REQ_REMOVE;
        else
          r.rq = (pick < 28) ? REQ_GRANT : (pick < 42) ? REQ_REVOKE :
                 (pick < 56) ? REQ_SET : (pick < 68) ? REQ_REMOVE :
                 (pick < 84) ? REQ_CONTAINS : (pick < 87) ? REQ_DEFAULT :
                 (pick < 92) ? (($urandom_range(0, 1) == 1) ? REQ_SPARE6 : REQ_SPARE7) :
                 REQ_GRANT;
        pick   = $urandom_range(0, 99);
        r.kind = (pick < 10) ? KIND_WORLD : (pick < 45) ? KIND_USER :
                 (pick < 80) ? KIND_GROUP : KIND_SPARE;
        r.id   = ($urandom_range(0, 99) < 85) ? ID_W'($urandom_range(0, 15)) : ID_W'($urandom);
        if (r.kind == KIND_WORLD && $urandom_range(0, 1) == 1) r.id = '0;
        r.mode = ($urandom_range(0, 9) == 0) ? '0 : MODE_BITS'($urandom_range(1, 127));
        if (r.rq == REQ_CONTAINS && $urandom_range(0, 1) == 1) begin
          for (int i = 0; i < acl_used; i++)
            if (acl[i].kind == r.kind && acl[i].id == r.id) r.mode = acl[i].mode;
        end
        if (r.rq == REQ_DEFAULT && $urandom_range(0, 1) == 1) r.id = '0;
        send_request(r);
        if (r.rq != REQ_SPARE6 && r.rq != REQ_SPARE7) useful++;
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (failures == 0 && outcome_q.size() == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

  initial begin : response_sink
    int stall;
    rsp_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      // long hold-off so the block backs up and stalls its input
      if (hold_request) begin
        hold_request = 1'b0;
        rsp_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (recv_calm > 0) begin
        recv_calm--;
        stall = 0;
      end else begin
        stall = $urandom_range(0, 5);
        if ($urandom_range(0, 29) == 0) recv_calm = $urandom_range(10, 30);
      end
      if (stall > 0) begin
        rsp_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready = 1'b1;
      do @(posedge clk); while (rsp_ch.valid !== 1'b1);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : scoreboard
    outcome_t got;
    outcome_t want;
    if (cfg_ch.valid && cfg_ch.ready) begin
      if (cfg_ch.index == CFG_OWNER_MODE) owner_cfg = cfg_ch.data;
      else if (cfg_ch.index == CFG_WORLD_MODE) world_cfg = cfg_ch.data;
    end
    if (rsp_ch.valid && rsp_ch.ready) begin
      got = '{rsp_ch.status, rsp_ch.matched, rsp_ch.result_mode, rsp_ch.entry_count};
      checked++;
      if (outcome_q.size() == 0) begin
        report_mismatch("response with nothing pending", 1, 0);
      end else begin
        want = outcome_q.pop_front();
        if (got.status !== want.status)
          report_mismatch("status", got.status, want.status);
        if (got.matched !== want.matched)
          report_mismatch("matched", got.matched, want.matched);
        if (got.result_mode !== want.result_mode)
          report_mismatch("result_mode", got.result_mode, want.result_mode);
        if (got.entry_count !== want.entry_count)
          report_mismatch("entry_count", got.entry_count, want.entry_count);
      end
    end
    // the shadow table is stepped on every request, typed rows included
    if (req_ch.valid && req_ch.ready) begin
      want = apply_acl_request(req_ch.req_type, req_ch.id_kind, req_ch.entry_id,
                               req_ch.mode_bits);
      outcome_q.push_back(cur_typed ? cur_want : want);
    end
  end

  always @(posedge clk) begin : watchdog
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

endmodule
`default_nettype wire

FILE: filelist.f
+incdir+hdl
hdl/sal_pkg.sv
hdl/sal_ifs.sv
hdl/sal_cell.sv
hdl/sorted_access_list_table_unit.sv
hdl/sal_checker.sv
sim/testbench.sv
